// ===== rtl/core/rti_pkg.sv =====
// Shared types and constants for the ray-triangle intersection core.
// Used by ray_triangle_intersect_core and rti_mul; depends on nothing else.
package rti_pkg;

    // Width of one operand slice in the pipelined multiplier.
    localparam int MUL_CHUNK = 32;

    // Barycentric weights: BARY_BITS fraction bits, one more bit so that one fits.
    localparam int BARY_BITS  = 16;
    localparam int BARY_OUT_W = BARY_BITS + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_ORIGIN_X = 3'd0;
    localparam cfg_idx_t REG_ORIGIN_Y = 3'd1;
    localparam cfg_idx_t REG_ORIGIN_Z = 3'd2;
    localparam cfg_idx_t REG_DIR_X    = 3'd3;
    localparam cfg_idx_t REG_DIR_Y    = 3'd4;
    localparam cfg_idx_t REG_DIR_Z    = 3'd5;
    localparam cfg_idx_t REG_MAX_DIST = 3'd6;

    // Axis codes used by the permutation.
    typedef logic [1:0] axis_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

endpackage

// ===== rtl/core/ray_triangle_intersect_core.sv =====
// The divider stages, one quotient bit each, make up most of the pipeline depth.
// Throughput: one triangle per cycle unless the output buffer is full.
// Every stage is a register with a shared advance.
// Reset: synchronous, active low; clears the valid bits and the output buffer and
// loads the ray registers with origin 0, direction +z and the largest distance.
module ray_triangle_intersect_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  rti_pkg::cfg_idx_t              cfg_index,
    input  logic [COORD_WIDTH-1:0]         cfg_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [COORD_WIDTH-1:0]  s_v0_x,
    input  logic signed [COORD_WIDTH-1:0]  s_v0_y,
    input  logic signed [COORD_WIDTH-1:0]  s_v0_z,
    input  logic signed [COORD_WIDTH-1:0]  s_v1_x,
    input  logic signed [COORD_WIDTH-1:0]  s_v1_y,
    input  logic signed [COORD_WIDTH-1:0]  s_v1_z,
    input  logic signed [COORD_WIDTH-1:0]  s_v2_x,
    input  logic signed [COORD_WIDTH-1:0]  s_v2_y,
    input  logic signed [COORD_WIDTH-1:0]  s_v2_z,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_hit,
    output logic [COORD_WIDTH-2:0]         m_hit_distance,
    output logic [rti_pkg::BARY_OUT_W-1:0] m_bary_0,
    output logic [rti_pkg::BARY_OUT_W-1:0] m_bary_1,
    output logic [rti_pkg::BARY_OUT_W-1:0] m_bary_2
);
    import rti_pkg::*;

    // Datapath widths. Every intermediate is kept exact; nothing saturates.
    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = W + 1;            // vertex minus origin
    localparam int MPW  = PW + W;           // shear products
    localparam int XW   = MPW + 1;          // sheared x and y, scaled by dz
    localparam int EPW  = 2 * XW;           // edge products
    localparam int EW   = EPW + 1;          // edge functions
    localparam int DETW = EW + 2;           // determinant
    localparam int NPW  = EW + PW;          // edge times z
    localparam int DPW  = DETW + W;         // determinant times dz
    localparam int LW   = 5 * W + 9;        // numerator and denominator, room to negate
    localparam int TPW  = W + LW;           // max distance times denominator
    localparam int CW   = TPW + F + 1;      // range compare width
    localparam int TNW  = LW + F + 1;       // distance dividend
    localparam int TDW  = LW + 1;           // distance divisor
    localparam int BNW  = EW + BARY_BITS + 2;
    localparam int BDW  = DETW + 2;
    localparam int QB   = (W > BARY_OUT_W) ? W : BARY_OUT_W;
    localparam int NST  = 15 + QB;          // pipeline register stages
    localparam int ODW  = 1 + (W - 1) + 3 * BARY_OUT_W;

    localparam logic [W-1:0] DIR_Z_RST = W'(1) << F;

    // ------------------------------------------------------------------
    // Ray registers. Writes must arrive only while the pipeline is empty;
    // the block does not enforce this, and the stages read them directly.
    // ------------------------------------------------------------------
    logic signed [W-1:0] org_x_reg, org_y_reg, org_z_reg;
    logic signed [W-1:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic [W-2:0]        tmax_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            dir_x_reg <= '0;
            dir_y_reg <= '0;
            dir_z_reg <= DIR_Z_RST;
            tmax_reg  <= '1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ORIGIN_X: org_x_reg <= cfg_data;
                REG_ORIGIN_Y: org_y_reg <= cfg_data;
                REG_ORIGIN_Z: org_z_reg <= cfg_data;
                REG_DIR_X:    dir_x_reg <= cfg_data;
                REG_DIR_Y:    dir_y_reg <= cfg_data;
                REG_DIR_Z:    dir_z_reg <= cfg_data;
                REG_MAX_DIST: tmax_reg  <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Axis permutation. The direction component of largest magnitude
    // becomes z; ties go to the later axis, so z wins any tie it is in.
    // ------------------------------------------------------------------
    logic [W-1:0] mag_x, mag_y, mag_z;
    axis_t        kx, ky, kz;
    logic signed [W-1:0] dx, dy, dz;

    assign mag_x = dir_x_reg[W-1] ? (~dir_x_reg + W'(1)) : dir_x_reg;
    assign mag_y = dir_y_reg[W-1] ? (~dir_y_reg + W'(1)) : dir_y_reg;
    assign mag_z = dir_z_reg[W-1] ? (~dir_z_reg + W'(1)) : dir_z_reg;

    always_comb begin
        if (mag_x > mag_y) begin
            kz = (mag_x > mag_z) ? AXIS_X : AXIS_Z;
        end else begin
            kz = (mag_y > mag_z) ? AXIS_Y : AXIS_Z;
        end
        unique case (kz)
            AXIS_X: begin
                kx = AXIS_Y;
                ky = AXIS_Z;
            end
            AXIS_Y: begin
                kx = AXIS_Z;
                ky = AXIS_X;
            end
            default: begin
                kx = AXIS_X;
                ky = AXIS_Y;
            end
        endcase
    end

    function automatic logic signed [W-1:0] pick_d(axis_t k, logic signed [W-1:0] a,
                                                   logic signed [W-1:0] b,
                                                   logic signed [W-1:0] c);
        logic signed [W-1:0] r;
        unique case (k)
            AXIS_X:  r = a;
            AXIS_Y:  r = b;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic signed [PW-1:0] pick_p(axis_t k, logic signed [PW-1:0] a,
                                                    logic signed [PW-1:0] b,
                                                    logic signed [PW-1:0] c);
        logic signed [PW-1:0] r;
        unique case (k)
            AXIS_X:  r = a;
            AXIS_Y:  r = b;
            default: r = c;
        endcase
        return r;
    endfunction

    assign dx = pick_d(kx, dir_x_reg, dir_y_reg, dir_z_reg);
    assign dy = pick_d(ky, dir_x_reg, dir_y_reg, dir_z_reg);
    assign dz = pick_d(kz, dir_x_reg, dir_y_reg, dir_z_reg);

    // ------------------------------------------------------------------
    // Pipeline control. All stages advance together; the output buffer
    // absorbs one finished result while the next one is still arriving.
    // ------------------------------------------------------------------
    logic           adv;
    logic           obuf_full;
    logic [NST:1]   vld_reg;

    assign adv     = !obuf_full;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-1:1], s_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: translate by the origin and permute.
    // ------------------------------------------------------------------
    logic signed [W-1:0]  vert [3][3];
    logic signed [PW-1:0] dlt  [3][3];
    logic signed [PW-1:0] px_s1_reg [3], py_s1_reg [3], pz_s1_reg [3];

    assign vert[0][0] = s_v0_x;
    assign vert[0][1] = s_v0_y;
    assign vert[0][2] = s_v0_z;
    assign vert[1][0] = s_v1_x;
    assign vert[1][1] = s_v1_y;
    assign vert[1][2] = s_v1_z;
    assign vert[2][0] = s_v2_x;
    assign vert[2][1] = s_v2_y;
    assign vert[2][2] = s_v2_z;

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            dlt[v][0] = PW'(vert[v][0]) - PW'(org_x_reg);
            dlt[v][1] = PW'(vert[v][1]) - PW'(org_y_reg);
            dlt[v][2] = PW'(vert[v][2]) - PW'(org_z_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int v = 0; v < 3; v++) begin
                px_s1_reg[v] <= pick_p(kx, dlt[v][0], dlt[v][1], dlt[v][2]);
                py_s1_reg[v] <= pick_p(ky, dlt[v][0], dlt[v][1], dlt[v][2]);
                pz_s1_reg[v] <= pick_p(kz, dlt[v][0], dlt[v][1], dlt[v][2]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 2-4: shear, scaled by dz so that nothing is divided.
    // ------------------------------------------------------------------
    logic signed [MPW-1:0] m_pxdz [3], m_dxpz [3], m_pydz [3], m_dypz [3];
    logic signed [PW-1:0]  pz_s2_reg [3], pz_s3_reg [3], pz_s4_reg [3];
    logic signed [XW-1:0]  xs_s4_reg [3], ys_s4_reg [3];

    for (genvar gv = 0; gv < 3; gv++) begin : g_shear
        rti_mul #(.AW(PW), .BW(W)) u_pxdz (
            .aclk(aclk), .en(adv), .a(px_s1_reg[gv]), .b(dz), .p(m_pxdz[gv])
        );
        rti_mul #(.AW(PW), .BW(W)) u_dxpz (
            .aclk(aclk), .en(adv), .a(pz_s1_reg[gv]), .b(dx), .p(m_dxpz[gv])
        );
        rti_mul #(.AW(PW), .BW(W)) u_pydz (
            .aclk(aclk), .en(adv), .a(py_s1_reg[gv]), .b(dz), .p(m_pydz[gv])
        );
        rti_mul #(.AW(PW), .BW(W)) u_dypz (
            .aclk(aclk), .en(adv), .a(pz_s1_reg[gv]), .b(dy), .p(m_dypz[gv])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int v = 0; v < 3; v++) begin
                pz_s2_reg[v] <= pz_s1_reg[v];
                pz_s3_reg[v] <= pz_s2_reg[v];
                pz_s4_reg[v] <= pz_s3_reg[v];
                xs_s4_reg[v] <= XW'(m_pxdz[v]) - XW'(m_dxpz[v]);
                ys_s4_reg[v] <= XW'(m_pydz[v]) - XW'(m_dypz[v]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 5-7: edge functions. Edge i pairs the two other vertices.
    // ------------------------------------------------------------------
    logic signed [EPW-1:0] m_e1 [3], m_e2 [3];
    logic signed [PW-1:0]  pz_s5_reg [3], pz_s6_reg [3], pz_s7_reg [3];
    logic signed [EW-1:0]  e_s7_reg [3];

    for (genvar ge = 0; ge < 3; ge++) begin : g_edge
        localparam int A = (ge + 1) % 3;
        localparam int B = (ge + 2) % 3;
        rti_mul #(.AW(XW), .BW(XW)) u_t1 (
            .aclk(aclk), .en(adv), .a(xs_s4_reg[A]), .b(ys_s4_reg[B]), .p(m_e1[ge])
        );
        rti_mul #(.AW(XW), .BW(XW)) u_t2 (
            .aclk(aclk), .en(adv), .a(ys_s4_reg[A]), .b(xs_s4_reg[B]), .p(m_e2[ge])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int v = 0; v < 3; v++) begin
                pz_s5_reg[v] <= pz_s4_reg[v];
                pz_s6_reg[v] <= pz_s5_reg[v];
                pz_s7_reg[v] <= pz_s6_reg[v];
                e_s7_reg[v]  <= EW'(m_e1[v]) - EW'(m_e2[v]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: determinant and the sign test. Mixed edge signs or a zero
    // determinant mark the triangle as missed; the flag rides along.
    // ------------------------------------------------------------------
    logic signed [DETW-1:0] det_c;
    logic                   any_neg, any_pos;
    logic signed [DETW-1:0] det_s8_reg;
    logic signed [EW-1:0]   e_s8_reg [3];
    logic signed [PW-1:0]   pz_s8_reg [3];
    logic                   ok_s8_reg;

    always_comb begin
        det_c   = DETW'(e_s7_reg[0]) + DETW'(e_s7_reg[1]) + DETW'(e_s7_reg[2]);
        any_neg = 1'b0;
        any_pos = 1'b0;
        for (int v = 0; v < 3; v++) begin
            if (e_s7_reg[v][EW-1]) begin
                any_neg = 1'b1;
            end else if (e_s7_reg[v] != '0) begin
                any_pos = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            det_s8_reg <= det_c;
            ok_s8_reg  <= !(any_neg && any_pos) && (det_c != '0);
            for (int v = 0; v < 3; v++) begin
                e_s8_reg[v]  <= e_s7_reg[v];
                pz_s8_reg[v] <= pz_s7_reg[v];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 9-11: distance numerator and denominator.
    // ------------------------------------------------------------------
    logic signed [NPW-1:0]  m_ez [3];
    logic signed [DPW-1:0]  m_dd;
    logic                   ok_s9_reg, ok_s10_reg, ok_s11_reg;
    logic signed [DETW-1:0] det_s9_reg, det_s10_reg, det_s11_reg;
    logic signed [EW-1:0]   e_s9_reg [3], e_s10_reg [3], e_s11_reg [3];
    logic signed [LW-1:0]   num_s11_reg, den_s11_reg;

    for (genvar gn = 0; gn < 3; gn++) begin : g_num
        rti_mul #(.AW(EW), .BW(PW)) u_ez (
            .aclk(aclk), .en(adv), .a(e_s8_reg[gn]), .b(pz_s8_reg[gn]), .p(m_ez[gn])
        );
    end

    rti_mul #(.AW(DETW), .BW(W)) u_dd (
        .aclk(aclk), .en(adv), .a(det_s8_reg), .b(dz), .p(m_dd)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            ok_s9_reg   <= ok_s8_reg;
            ok_s10_reg  <= ok_s9_reg;
            ok_s11_reg  <= ok_s10_reg;
            det_s9_reg  <= det_s8_reg;
            det_s10_reg <= det_s9_reg;
            det_s11_reg <= det_s10_reg;
            for (int v = 0; v < 3; v++) begin
                e_s9_reg[v]  <= e_s8_reg[v];
                e_s10_reg[v] <= e_s9_reg[v];
                e_s11_reg[v] <= e_s10_reg[v];
            end
            num_s11_reg <= LW'(m_ez[0]) + LW'(m_ez[1]) + LW'(m_ez[2]);
            den_s11_reg <= LW'(m_dd);
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: make the denominator positive and require a positive
    // distance; fold the determinant sign into the weights as well.
    // ------------------------------------------------------------------
    logic signed [LW-1:0]   num_fix, den_fix;
    logic signed [DETW:0]   det_wide;
    logic signed [EW:0]     e_wide [3];
    logic signed [LW-1:0]   num_s12_reg, den_s12_reg;
    logic                   ok_s12_reg;
    logic [DETW:0]          dabs_s12_reg;
    logic [EW:0]            eabs_s12_reg [3];

    always_comb begin
        if (den_s11_reg[LW-1]) begin
            num_fix = -num_s11_reg;
            den_fix = -den_s11_reg;
        end else begin
            num_fix = num_s11_reg;
            den_fix = den_s11_reg;
        end
        det_wide = (DETW+1)'(det_s11_reg);
        for (int v = 0; v < 3; v++) begin
            e_wide[v] = (EW+1)'(e_s11_reg[v]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_s12_reg  <= num_fix;
            den_s12_reg  <= den_fix;
            ok_s12_reg   <= ok_s11_reg && (den_fix != '0) && !num_fix[LW-1]
                            && (num_fix != '0);
            dabs_s12_reg <= det_wide[DETW] ? -det_wide : det_wide;
            for (int v = 0; v < 3; v++) begin
                eabs_s12_reg[v] <= det_wide[DETW] ? -e_wide[v] : e_wide[v];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 13-15: range check against max_distance, then the operands
    // of the rounding dividers: (2n * 2^s + d) / (2d) rounds halves up.
    // ------------------------------------------------------------------
    logic signed [W-1:0]   tmax_s;
    logic signed [TPW-1:0] m_tl;
    logic signed [LW-1:0]  num_s13_reg, num_s14_reg, den_s13_reg, den_s14_reg;
    logic                  ok_s13_reg, ok_s14_reg, ok_s15_reg;
    logic [DETW:0]         dabs_s13_reg, dabs_s14_reg;
    logic [EW:0]           eabs_s13_reg [3], eabs_s14_reg [3];
    logic [CW-1:0]         lhs, rhs;
    logic [TNW-1:0]        tnum_s15_reg;
    logic [TDW-1:0]        tden_s15_reg;
    logic [BNW-1:0]        bnum_s15_reg [3];
    logic [BDW-1:0]        bden_s15_reg;

    assign tmax_s = {1'b0, tmax_reg};

    rti_mul #(.AW(W), .BW(LW)) u_tl (
        .aclk(aclk), .en(adv), .a(tmax_s), .b(den_s12_reg), .p(m_tl)
    );

    assign lhs = CW'($unsigned(num_s14_reg)) << F;
    assign rhs = CW'($unsigned(m_tl));

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_s13_reg  <= num_s12_reg;
            num_s14_reg  <= num_s13_reg;
            den_s13_reg  <= den_s12_reg;
            den_s14_reg  <= den_s13_reg;
            ok_s13_reg   <= ok_s12_reg;
            ok_s14_reg   <= ok_s13_reg;
            dabs_s13_reg <= dabs_s12_reg;
            dabs_s14_reg <= dabs_s13_reg;
            for (int v = 0; v < 3; v++) begin
                eabs_s13_reg[v] <= eabs_s12_reg[v];
                eabs_s14_reg[v] <= eabs_s13_reg[v];
                bnum_s15_reg[v] <= (BNW'(eabs_s14_reg[v]) << (BARY_BITS + 1))
                                   + BNW'(dabs_s14_reg);
            end
            ok_s15_reg   <= ok_s14_reg && !(lhs > rhs);
            tnum_s15_reg <= (TNW'($unsigned(num_s14_reg)) << (F + 1))
                            + TNW'($unsigned(den_s14_reg));
            tden_s15_reg <= TDW'($unsigned(den_s14_reg)) << 1;
            bden_s15_reg <= BDW'(dabs_s14_reg) << 1;
        end
    end

    // ------------------------------------------------------------------
    // Stages 16 to 15+QB: one distance divider and three weight dividers
    // in parallel; the hit flag follows them through a matching delay.
    // ------------------------------------------------------------------
    logic [QB-1:0] tq;
    logic [QB-1:0] bq [3];
    logic [QB-1:0] ok_dly_reg;

    rti_div #(.NW(TNW), .DW(TDW), .QB(QB)) u_tdiv (
        .aclk(aclk), .en(adv), .num(tnum_s15_reg), .den(tden_s15_reg), .q(tq)
    );

    for (genvar gb = 0; gb < 3; gb++) begin : g_bdiv
        rti_div #(.NW(BNW), .DW(BDW), .QB(QB)) u_bdiv (
            .aclk(aclk), .en(adv), .num(bnum_s15_reg[gb]), .den(bden_s15_reg), .q(bq[gb])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ok_dly_reg <= {ok_dly_reg[QB-2:0], ok_s15_reg};
        end
    end

    // ------------------------------------------------------------------
    // Result formatting. A hit whose distance rounds to zero reports the
    // smallest step; a miss reports all zeros.
    // ------------------------------------------------------------------
    logic              hit_c;
    logic [QB-1:0]     dist_full;
    logic [ODW-1:0]    res_c;
    logic [ODW-1:0]    res_q;
    logic              push;

    assign hit_c     = ok_dly_reg[QB-1];
    assign dist_full = (tq == '0) ? QB'(1) : tq;

    always_comb begin
        if (hit_c) begin
            res_c = {1'b1, dist_full[W-2:0], bq[0][BARY_OUT_W-1:0],
                     bq[1][BARY_OUT_W-1:0], bq[2][BARY_OUT_W-1:0]};
        end else begin
            res_c = '0;
        end
    end

    assign push = adv && vld_reg[NST];

    rti_obuf #(.DW(ODW)) u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (res_c),
        .full      (obuf_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (res_q)
    );

    assign {m_hit, m_hit_distance, m_bary_0, m_bary_1, m_bary_2} = res_q;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    localparam logic [BARY_OUT_W-1:0] BARY_ONE = BARY_OUT_W'(1) << BARY_BITS;

    // A missed triangle must leave every result field at zero.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_hit_distance == '0 && m_bary_0 == '0
                                 && m_bary_1 == '0 && m_bary_2 == '0))
        else $error("miss transaction carries nonzero fields");

    // A weight never exceeds one.
    a_bary_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bary_0 <= BARY_ONE && m_bary_1 <= BARY_ONE
                     && m_bary_2 <= BARY_ONE))
        else $error("barycentric weight above one");

    // While the output buffer is full the pipeline must hold its contents.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

endmodule

// ===== rtl/core/rti_mul.sv =====
// Two-stage signed multiplier built from slice products and a summing stage.
// Depends on rti_pkg for the slice width.
module rti_mul #(
    parameter int AW = 33,
    parameter int BW = 32
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [AW-1:0]      a,
    input  logic signed [BW-1:0]      b,
    output logic signed [AW+BW-1:0]   p
);
    import rti_pkg::*;

    localparam int CH  = MUL_CHUNK;
    localparam int NA  = (AW + CH - 1) / CH;
    localparam int NB  = (BW + CH - 1) / CH;
    localparam int AXW = NA * CH;
    localparam int BXW = NB * CH;
    localparam int PPW = 2 * CH + 2;
    localparam int PW  = AW + BW;

    logic signed [AXW-1:0] ax;
    logic signed [BXW-1:0] bx;
    logic signed [CH:0]    ac [NA];
    logic signed [CH:0]    bc [NB];
    logic signed [PPW-1:0] pp_reg [NA][NB];
    logic signed [PW-1:0]  acc;
    logic signed [PW-1:0]  p_reg;

    assign ax = AXW'(a);
    assign bx = BXW'(b);

    // The top slice carries the sign, the lower slices are plain magnitudes.
    for (genvar gi = 0; gi < NA; gi++) begin : g_a
        if (gi == NA - 1) begin : g_top
            assign ac[gi] = {ax[AXW-1], ax[gi*CH +: CH]};
        end else begin : g_low
            assign ac[gi] = {1'b0, ax[gi*CH +: CH]};
        end
    end

    for (genvar gj = 0; gj < NB; gj++) begin : g_b
        if (gj == NB - 1) begin : g_top
            assign bc[gj] = {bx[BXW-1], bx[gj*CH +: CH]};
        end else begin : g_low
            assign bc[gj] = {1'b0, bx[gj*CH +: CH]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= PPW'(ac[i]) * PPW'(bc[j]);
                end
            end
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (PW'(pp_reg[i][j]) <<< ((i + j) * CH));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= acc;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/core/rti_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, QB stages deep.
// Depends on no package; the caller guarantees the quotient fits in QB bits.
module rti_div #(
    parameter int NW = 64,
    parameter int DW = 32,
    parameter int QB = 32
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] q
);
    localparam int RW = (NW > DW + QB) ? NW : DW + QB;

    logic [RW-1:0] rem_reg [QB-1];
    logic [DW-1:0] den_reg [QB-1];
    logic [QB-1:0] quo_reg [QB];

    for (genvar gs = 0; gs < QB; gs++) begin : g_st
        localparam int B = QB - 1 - gs;

        logic [RW-1:0] rem_cur;
        logic [RW-1:0] sub_val;
        logic [DW-1:0] den_cur;
        logic [QB-1:0] quo_cur;
        logic          ge;

        if (gs == 0) begin : g_in
            assign rem_cur = RW'(num);
            assign den_cur = den;
            assign quo_cur = '0;
        end else begin : g_mid
            assign rem_cur = rem_reg[gs-1];
            assign den_cur = den_reg[gs-1];
            assign quo_cur = quo_reg[gs-1];
        end

        assign sub_val = RW'(den_cur) << B;
        assign ge      = (rem_cur >= sub_val);

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[gs] <= quo_cur | (QB'(ge) << B);
            end
        end

        if (gs < QB - 1) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[gs] <= ge ? (rem_cur - sub_val) : rem_cur;
                    den_reg[gs] <= den_cur;
                end
            end
        end
    end

    assign q = quo_reg[QB-1];

endmodule

// ===== rtl/core/rti_obuf.sv =====
// Two-entry output buffer that decouples the pipeline from the result channel.
// Depends on no package.
module rti_obuf #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          full,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [DW-1:0] m_data
);
    logic [DW-1:0] mem_reg [2];
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    logic          wr_reg;
    logic          rd_reg;
    logic          pop;

    assign pop      = m_valid && m_ready;
    assign cnt_next = cnt_reg + 2'(push) - 2'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    assign full    = (cnt_reg == 2'd2);
    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = mem_reg[rd_reg];

endmodule
